// ===== rtl/core/gtu_pkg.sv =====
`default_nettype none

package gtu_pkg;

  localparam int LEN_W       = 16;
  localparam int CP_W        = 16;
  localparam int TABLE_ROWS  = 126;
  localparam int TABLE_COLS  = 190;
  localparam int TABLE_DEPTH = TABLE_ROWS * TABLE_COLS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT = 16'hFFFD;

  localparam logic ACT_CONVERT = 1'b0;
  localparam logic ACT_TABLE   = 1'b1;

  // item classes between the front's stages
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_WRITE  = 2'd3;

  typedef struct packed {
    logic            has_char;
    logic [CP_W-1:0] cp;
    logic            last;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/gtu_intf.sv =====
`default_nettype none

interface gtu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        last;
  logic [14:0] table_index;
  logic [15:0] table_value;

  modport source (output valid, action, data_byte, last, table_index, table_value,
                  input ready);
  modport sink   (input valid, action, data_byte, last, table_index, table_value,
                  output ready);
endinterface

interface gtu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        char_end;
  logic        message_end;
  logic [15:0] out_length;

  modport source (output valid, out_byte, char_end, message_end, out_length,
                  input ready);
  modport sink   (input valid, out_byte, char_end, message_end, out_length,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gbk_to_utf8_transcoder_top.sv =====
// GBK to UTF-8 transcoder.
// in_ch carries one item per handshake: action 0 converts data_byte (last ends
// the message), action 1 writes table_value into the code point table at
// table_index. The table must be loaded before any pair that reads an entry.
// out_ch carries one UTF-8 byte per handshake; message end is a NUL item with
// message_end set and out_length giving the bytes written before it.
// cfg_we/cfg_wdata set the output capacity (bytes, terminator included);
// write it only while the block is idle.
// Front: accepts one item per cycle while in_ch.ready is high, classifies it
// and reads the table in a two-stage pipeline. A 4-entry queue separates it
// from the back end, which makes the capacity decision and emits one result
// per cycle while out_ch.ready is high, from a registered output.
// The back end takes a new item only as the last result of the current one
// leaves; items with no result are consumed without making output.
// Reset (synchronous, rst_n low) clears the message state and the queue and
// sets the capacity to 65535; the table contents are kept, not cleared.
// When out_ch.ready is low the output byte holds, the queue fills and then
// in_ch.ready drops; nothing is lost.
`default_nettype none

module gbk_to_utf8_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  gtu_in_if.sink      in_ch,
  gtu_out_if.source   out_ch
);
  import gtu_pkg::*;

  logic     f_push_valid, f_push_ready;
  q_entry_t f_push_data;
  logic     q_pop_valid, q_pop_ready;
  q_entry_t q_pop_data;

  gtu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_push_valid),
    .push_data  (f_push_data),
    .push_ready (f_push_ready)
  );

  gtu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_data  (f_push_data),
    .push_ready (f_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_data   (q_pop_data),
    .pop_ready  (q_pop_ready)
  );

  gtu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (q_pop_valid),
    .pop_data  (q_pop_data),
    .pop_ready (q_pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gtu_front.sv =====
`default_nettype none

module gtu_front (
  input  logic              clk,
  input  logic              rst_n,
  gtu_in_if.sink            in_ch,
  output logic              push_valid,
  output gtu_pkg::q_entry_t push_data,
  input  logic              push_ready
);
  import gtu_pkg::*;

  logic [CP_W-1:0] mem [TABLE_DEPTH];

  logic             lead_r, lead_nxt;
  logic [7:0]       held_r, held_nxt;

  logic             s1_v_r, s2_v_r;
  logic [1:0]       s1_kind_r, s2_kind_r;
  logic [CP_W-1:0]  s1_cp_r, s2_cp_r;
  logic             s1_last_r, s2_last_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [CP_W-1:0]  rd_r;

  logic             accept, en1, en2, s2_push;
  logic [7:0]       col;
  logic             col_ok, lead_ok;
  logic [6:0]       row;
  logic [ADDR_W-1:0] pair_addr;
  logic [1:0]       kind_c;
  logic [CP_W-1:0]  cp_c;
  logic [ADDR_W-1:0] addr_c;
  logic             last_c;

  assign s2_push = (s2_kind_r == KIND_CHAR) || (s2_kind_r == KIND_LOOKUP) || s2_last_r;
  assign en2     = !s2_v_r || !s2_push || push_ready;
  assign en1     = !s1_v_r || en2;
  assign in_ch.ready = en1;
  assign accept  = in_ch.valid && en1;

  // trail byte to table column
  always_comb begin
    col    = 8'd0;
    col_ok = 1'b0;
    if (in_ch.data_byte >= 8'h40 && in_ch.data_byte <= 8'h7E) begin
      col    = in_ch.data_byte - 8'h40;
      col_ok = 1'b1;
    end else if (in_ch.data_byte >= 8'h80 && in_ch.data_byte <= 8'hFE) begin
      col    = in_ch.data_byte - 8'h80 + 8'd63;
      col_ok = 1'b1;
    end
  end

  assign lead_ok   = (held_r >= 8'h81) && (held_r <= 8'hFE);
  assign row       = 7'(held_r - 8'h81);
  assign pair_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(TABLE_COLS)) + ADDR_W'(col);

  always_comb begin
    kind_c   = KIND_NONE;
    cp_c     = {8'h00, in_ch.data_byte};
    addr_c   = pair_addr;
    lead_nxt = lead_r;
    held_nxt = held_r;
    if (in_ch.action == ACT_TABLE) begin
      cp_c   = in_ch.table_value;
      addr_c = in_ch.table_index;
      if (32'(in_ch.table_index) < TABLE_DEPTH) begin
        kind_c = KIND_WRITE;
      end
    end else if (lead_r) begin
      lead_nxt = 1'b0;
      if (col_ok && lead_ok) begin
        kind_c = KIND_LOOKUP;
      end else begin
        kind_c = KIND_CHAR;
        cp_c   = REPLACEMENT;
      end
    end else if (!in_ch.data_byte[7]) begin
      kind_c = KIND_CHAR;
    end else begin
      held_nxt = in_ch.data_byte;
      lead_nxt = 1'b1;
    end
    last_c = (in_ch.action == ACT_CONVERT) && in_ch.last;
    // a lead byte left open at message end is dropped
    if (last_c) begin
      lead_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 1'b0;
      held_r <= 8'h00;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        lead_r <= lead_nxt;
        held_r <= held_nxt;
      end
      if (en1) begin
        s1_v_r <= accept;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= kind_c;
      s1_cp_r   <= cp_c;
      s1_last_r <= last_c;
      s1_addr_r <= addr_c;
    end
    if (en2) begin
      s2_kind_r <= s1_kind_r;
      s2_cp_r   <= s1_cp_r;
      s2_last_r <= s1_last_r;
    end
  end

  // table: one write and one registered read port, both from stage 1
  always_ff @(posedge clk) begin
    if (s1_v_r && en2 && s1_kind_r == KIND_WRITE) begin
      mem[s1_addr_r] <= s1_cp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rd_r <= mem[s1_addr_r];
    end
  end

  assign push_valid     = s2_v_r && s2_push;
  assign push_data.has_char = (s2_kind_r == KIND_CHAR) || (s2_kind_r == KIND_LOOKUP);
  assign push_data.last = s2_last_r;
  assign push_data.cp   = (s2_kind_r == KIND_LOOKUP) ?
                          ((rd_r == '0) ? REPLACEMENT : rd_r) : s2_cp_r;

  a_lead_cleared_by_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_c |=> !lead_r)
    else $error("lead byte still pending after message end");

endmodule

`default_nettype wire

// ===== rtl/core/gtu_queue.sv =====
`default_nettype none

module gtu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  gtu_pkg::q_entry_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output gtu_pkg::q_entry_t pop_data,
  input  logic              pop_ready
);
  import gtu_pkg::*;

  q_entry_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/core/gtu_back.sv =====
`default_nettype none

module gtu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              pop_valid,
  input  gtu_pkg::q_entry_t pop_data,
  output logic              pop_ready,
  gtu_out_if.source         out_ch
);
  import gtu_pkg::*;

  logic [15:0]      cap_r;
  logic [LEN_W-1:0] bw_r, term_len_r;
  logic             stop_r, busy_r;
  logic [7:0]       b0_r, b1_r, b2_r;
  logic [1:0]       nb_r, k_r;
  logic [2:0]       tot_r;

  logic             out_v_r, out_ce_r, out_me_r;
  logic [7:0]       out_byte_r;
  logic [LEN_W-1:0] out_len_r;

  logic [CP_W-1:0]  cp;
  logic [1:0]       need, nb_c;
  logic [16:0]      eff_cap;
  logic             fits, emit, stop_after;
  logic [LEN_W-1:0] bw_after;
  logic [2:0]       tot_c;
  logic [7:0]       b0_c, b1_c, b2_c;
  logic             adv, last_slot, free, load;
  logic [7:0]       slot_byte;

  assign cp   = pop_data.cp;
  assign need = (cp < 16'h0080) ? 2'd1 : ((cp < 16'h0800) ? 2'd2 : 2'd3);
  assign eff_cap = (cap_r == 16'd0) ? 17'd1 : {1'b0, cap_r};
  // a character must leave room for the terminator
  assign fits = ({1'b0, bw_r} + 17'(need)) < eff_cap;
  assign emit = pop_data.has_char && !stop_r && fits;
  assign stop_after = stop_r || (pop_data.has_char && !fits);
  assign nb_c     = emit ? need : 2'd0;
  assign bw_after = bw_r + LEN_W'(nb_c);
  assign tot_c    = 3'(nb_c) + 3'(pop_data.last);

  always_comb begin
    b0_c = cp[7:0];
    b1_c = 8'h00;
    b2_c = 8'h00;
    unique case (need)
      2'd2: begin
        b0_c = 8'hC0 | {3'b000, cp[10:6]};
        b1_c = 8'h80 | {2'b00, cp[5:0]};
      end
      2'd3: begin
        b0_c = 8'hE0 | {4'h0, cp[15:12]};
        b1_c = 8'h80 | {2'b00, cp[11:6]};
        b2_c = 8'h80 | {2'b00, cp[5:0]};
      end
      default: begin
        b0_c = cp[7:0];
      end
    endcase
  end

  assign adv       = !out_v_r || out_ch.ready;
  assign last_slot = busy_r && ({1'b0, k_r} == tot_r - 3'd1);
  assign free      = !busy_r || (adv && last_slot);
  assign pop_ready = free;
  assign load      = pop_valid && free;

  always_comb begin
    unique case (k_r)
      2'd0:    slot_byte = b0_r;
      2'd1:    slot_byte = b1_r;
      default: slot_byte = b2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= 16'hFFFF;
      bw_r    <= '0;
      stop_r  <= 1'b0;
      busy_r  <= 1'b0;
      k_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (adv) begin
        out_v_r <= busy_r;
      end
      if (load) begin
        busy_r <= (tot_c != 3'd0);
        k_r    <= '0;
        bw_r   <= pop_data.last ? '0 : bw_after;
        stop_r <= pop_data.last ? 1'b0 : stop_after;
      end else if (adv && busy_r) begin
        k_r <= k_r + 1'b1;
        if (last_slot) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0_r       <= b0_c;
      b1_r       <= b1_c;
      b2_r       <= b2_c;
      nb_r       <= nb_c;
      tot_r      <= tot_c;
      term_len_r <= bw_after;
    end
    if (adv && busy_r) begin
      if (k_r < nb_r) begin
        out_byte_r <= slot_byte;
        out_ce_r   <= (k_r == nb_r - 2'd1);
        out_me_r   <= 1'b0;
        out_len_r  <= '0;
      end else begin
        out_byte_r <= 8'h00;
        out_ce_r   <= 1'b1;
        out_me_r   <= 1'b1;
        out_len_r  <= term_len_r;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.char_end    = out_ce_r;
  assign out_ch.message_end = out_me_r;
  assign out_ch.out_length  = out_len_r;

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, k_r} < tot_r))
    else $error("result slot past end of item");

  a_term_ends_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_me_r |-> out_ce_r && out_byte_r == 8'h00)
    else $error("terminator malformed");

  a_len_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_me_r |-> out_len_r == '0)
    else $error("length on a non-terminator byte");

endmodule

`default_nettype wire
